// File: src/iru_pkg.sv
package iru_pkg;

    // line store geometry and factor limit
    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_FACTOR = 100;
    localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);

    // field widths
    localparam int unsigned FACTOR_W = 7;
    localparam int unsigned WIDTH_W  = 12;
    localparam int unsigned ROWS_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // request function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // result status codes
    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_PAD     = 3'd1;
    localparam logic [2:0] ST_LOADED  = 3'd2;
    localparam logic [2:0] ST_STALL   = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // result flags carried alongside the line store read
    typedef struct packed {
        logic [2:0] status;
        logic       end_of_line;
        logic       end_of_image;
    } res_ctl_t;

endpackage

// File: src/iru_if.sv
interface iru_in_if;
    import iru_pkg::*;

    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, func, red_in, green_in, blue_in, input ready);
    modport sink (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface iru_out_if;
    import iru_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_line;
    logic       end_of_image;

    modport source (output valid, status, red_out, green_out, blue_out, end_of_line,
                    end_of_image, input ready);
    modport sink (input valid, status, red_out, green_out, blue_out, end_of_line,
                  end_of_image, output ready);
endinterface

// File: src/integer_pixel_replication_upscaler.sv
// Nearest-neighbour upscaler for 24-bit RGB. A load request writes the next source
// pixel of the current row into the line store, or is refused once the row is loaded,
// while it is replayed or after the image is done; a tick request returns the next
// output element (pixel copy, zero pad byte, stall or done). Exactly one result comes
// back per request, in order. One request is taken every clock cycle; each result
// passes through the line store read stage and then the output register. Each request
// makes at most one line store access, so only result back-pressure lowers this rate:
// requests stall once both the read stage and the output register are full. A write to
// the factor, width or rows register restarts the image; the line store keeps its contents.
module integer_pixel_replication_upscaler
    import iru_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    iru_in_if.sink                item,
    iru_out_if.source             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [FACTOR_W-1:0] factor_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic                restart;

    // effective geometry
    logic [FACTOR_W-1:0] factor_eff;
    logic [WIDTH_W-1:0]  width_eff;
    logic [ROWS_W-1:0]   rows_eff;
    logic [1:0]          row_bytes_low;
    logic [1:0]          npad;

    // scan state
    logic [WIDTH_W-1:0]  loaded_reg, loaded_next;
    logic [ROWS_W-1:0]   src_row_reg, src_row_next;
    logic [FACTOR_W-1:0] rep_reg, rep_next;
    logic [WIDTH_W-1:0]  col_reg, col_next;
    logic [FACTOR_W-1:0] copy_reg, copy_next;
    logic [1:0]          pad_reg, pad_next;
    logic                fin_reg, fin_next;
    logic                in_pad_reg, in_pad_next;

    // step logic
    logic                accept;
    logic                mem_wr;
    logic                mem_rd;
    logic                finish_row;
    res_ctl_t            step_ctl;
    logic [FACTOR_W:0]   copy_inc;
    logic [WIDTH_W:0]    col_inc;
    logic [2:0]          pad_inc;
    logic [FACTOR_W:0]   rep_inc;
    logic [ROWS_W:0]     row_inc;
    pixel_t              wr_pixel;
    pixel_t              rd_pixel;

    // read stage and output register
    logic                s1_valid_reg;
    res_ctl_t            s1_ctl_reg;
    logic                s1_advance;
    logic                out_valid_reg;
    res_ctl_t            out_ctl_reg;
    pixel_t              out_pixel_reg;

    // config decode
    always_comb
    begin
        restart = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FACTOR, CFG_WIDTH, CFG_ROWS: restart = 1'b1;
                default:                         restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_W'(1);
            width_reg  <= WIDTH_W'(1);
            rows_reg   <= ROWS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_ROWS:   rows_reg   <= cfg_data[ROWS_W-1:0];
                default:    factor_reg <= factor_reg;
            endcase
        end
    end

    // clamp out-of-range settings
    always_comb
    begin
        if (factor_reg == '0)
            factor_eff = FACTOR_W'(1);
        else if (factor_reg > FACTOR_W'(MAX_FACTOR))
            factor_eff = FACTOR_W'(MAX_FACTOR);
        else
            factor_eff = factor_reg;

        if (width_reg == '0)
            width_eff = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            width_eff = WIDTH_W'(MAX_WIDTH);
        else
            width_eff = width_reg;

        rows_eff = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
    end

    // pad bytes to a 4-byte boundary only depend on the low bits
    assign row_bytes_low = 2'(width_eff[1:0] * factor_eff[1:0] * 2'd3);
    assign npad          = 2'(~row_bytes_low + 2'd1);

    // handshake: take a request whenever the read stage is empty or can move on
    assign s1_advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_advance;
    assign accept     = item.valid && item.ready;

    assign copy_inc = {1'b0, copy_reg} + 1'b1;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign pad_inc  = {1'b0, pad_reg} + 1'b1;
    assign rep_inc  = {1'b0, rep_reg} + 1'b1;
    assign row_inc  = {1'b0, src_row_reg} + 1'b1;

    // per-request state step
    always_comb
    begin
        loaded_next  = loaded_reg;
        src_row_next = src_row_reg;
        rep_next     = rep_reg;
        col_next     = col_reg;
        copy_next    = copy_reg;
        pad_next     = pad_reg;
        fin_next     = fin_reg;
        in_pad_next  = in_pad_reg;
        mem_wr       = 1'b0;
        mem_rd       = 1'b0;
        finish_row   = 1'b0;
        step_ctl     = '{status: ST_REFUSED, end_of_line: 1'b0, end_of_image: 1'b0};

        if (accept)
        begin
            if (item.func == FUNC_LOAD)
            begin
                if (!fin_reg && rep_reg == '0 && loaded_reg < width_eff)
                begin
                    mem_wr          = 1'b1;
                    loaded_next     = loaded_reg + 1'b1;
                    step_ctl.status = ST_LOADED;
                end
            end
            else if (fin_reg)
            begin
                step_ctl.status = ST_DONE;
            end
            else if (in_pad_reg)
            begin
                step_ctl.status = ST_PAD;
                pad_next        = pad_inc[1:0];
                if (pad_inc >= {1'b0, npad})
                begin
                    finish_row = 1'b1;
                end
            end
            else if (col_reg >= loaded_reg)
            begin
                step_ctl.status = ST_STALL;
            end
            else
            begin
                step_ctl.status = ST_PIXEL;
                mem_rd          = 1'b1;
                copy_next       = copy_inc[FACTOR_W-1:0];
                if (copy_inc >= {1'b0, factor_eff})
                begin
                    copy_next = '0;
                    col_next  = col_inc[WIDTH_W-1:0];
                    if (col_inc >= {1'b0, width_eff})
                    begin
                        if (npad == 2'd0)
                        begin
                            finish_row = 1'b1;
                        end
                        else
                        begin
                            in_pad_next = 1'b1;
                            pad_next    = '0;
                        end
                    end
                end
            end
        end

        // close an output row, advance row repeat and source row
        if (finish_row)
        begin
            step_ctl.end_of_line = 1'b1;
            col_next             = '0;
            copy_next            = '0;
            pad_next             = '0;
            in_pad_next          = 1'b0;
            rep_next             = rep_inc[FACTOR_W-1:0];
            if (rep_inc >= {1'b0, factor_eff})
            begin
                rep_next     = '0;
                loaded_next  = '0;
                src_row_next = row_inc[ROWS_W-1:0];
                if (row_inc >= {1'b0, rows_eff})
                begin
                    fin_next              = 1'b1;
                    step_ctl.end_of_image = 1'b1;
                end
            end
        end
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg  <= '0;
            src_row_reg <= '0;
            rep_reg     <= '0;
            col_reg     <= '0;
            copy_reg    <= '0;
            pad_reg     <= '0;
            fin_reg     <= 1'b0;
            in_pad_reg  <= 1'b0;
        end
        else if (restart)
        begin
            loaded_reg  <= '0;
            src_row_reg <= '0;
            rep_reg     <= '0;
            col_reg     <= '0;
            copy_reg    <= '0;
            pad_reg     <= '0;
            fin_reg     <= 1'b0;
            in_pad_reg  <= 1'b0;
        end
        else
        begin
            loaded_reg  <= loaded_next;
            src_row_reg <= src_row_next;
            rep_reg     <= rep_next;
            col_reg     <= col_next;
            copy_reg    <= copy_next;
            pad_reg     <= pad_next;
            fin_reg     <= fin_next;
            in_pad_reg  <= in_pad_next;
        end
    end

    // line store
    assign wr_pixel = '{red: item.red_in, green: item.green_in, blue: item.blue_in};

    iru_line_mem u_line_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (loaded_reg[ADDR_W-1:0]),
        .wr_data (wr_pixel),
        .rd_en   (mem_rd),
        .rd_addr (col_reg[ADDR_W-1:0]),
        .rd_data (rd_pixel)
    );

    // read stage: flags wait here for the line store data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= step_ctl;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_ctl_reg   <= s1_ctl_reg;
            out_pixel_reg <= (s1_ctl_reg.status == ST_PIXEL) ? rd_pixel : pixel_t'('0);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_ctl_reg.status;
    assign result.red_out      = out_pixel_reg.red;
    assign result.green_out    = out_pixel_reg.green;
    assign result.blue_out     = out_pixel_reg.blue;
    assign result.end_of_line  = out_ctl_reg.end_of_line;
    assign result.end_of_image = out_ctl_reg.end_of_image;

    // replay never reads past the loaded part of the row
    a_col_within_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= loaded_reg)
        else $error("column index beyond loaded pixels");

    // a row is only replayed once it is fully loaded
    a_repeat_needs_full_row: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg != '0 |-> loaded_reg == width_eff)
        else $error("row repeat started on a partial row");

    // pad phase stays below the pad count
    a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_pad_reg |-> ({1'b0, pad_reg} < {1'b0, npad}))
        else $error("pad counter beyond pad length");

endmodule

// File: src/iru_line_mem.sv
module iru_line_mem
    import iru_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pixel_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pixel_t            rd_data
);

    pixel_t mem [MAX_WIDTH];
    pixel_t rd_data_reg;

    // one row of source pixels
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
